/* hdl/pmss_pkg.sv */
`default_nettype none

package pmss_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int WORD_W    = 32;
   localparam int PRIO_W    = 5;
   localparam int FUNC_W    = 2;

   localparam logic [CNT_W-1:0] RING_RESET = CNT_W'(MAX_SLOTS);
   localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_SLOTS);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE   = 2'd0,
      FUNC_READ    = 2'd1,
      FUNC_ARRANGE = 2'd2
   } func_type;

   typedef struct packed {
      logic [WORD_W-1:0] first;
      logic [WORD_W-1:0] second;
      logic [PRIO_W-1:0] prio;
      logic [WORD_W-1:0] order;
   } slot_word_type;

   typedef struct packed {
      logic capture;
      logic wr_input;
      logic rd_issue;
      logic scan_issue;
      logic wr_head;
      logic wr_best;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     cnt_zero;
      logic     cnt_last;
   } status_type;

endpackage

`default_nettype wire

/* hdl/priority_message_select_swap_unit.sv */
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  func, slot, payloads, priority, order, head, count
// rsp_      out        rsp_valid/rsp_stall  slot read, top_priority, found
// csr_      in         csr_valid/csr_ready  ring_slots (7 bits)
//
// One transaction is worked at a time. Write and read each make one store access;
// arrange makes one store read per scanned slot through the single read port, then
// two writes for the swap.
// A new transaction is accepted while the previous result still waits on rsp_stall.
// Reset clears control and sets ring_slots to 64; the store is not cleared.
// csr_ready is always high.

module priority_message_select_swap_unit
   import pmss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [SLOT_W-1:0] req_slot,
   input  wire logic [WORD_W-1:0] req_payload_first,
   input  wire logic [WORD_W-1:0] req_payload_second,
   input  wire logic [PRIO_W-1:0] req_msg_priority,
   input  wire logic [WORD_W-1:0] req_arrival_order,
   input  wire logic [SLOT_W-1:0] req_head_slot,
   input  wire logic [CNT_W-1:0]  req_entry_count,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [WORD_W-1:0]      rsp_out_payload_first,
   output logic [WORD_W-1:0]      rsp_out_payload_second,
   output logic [PRIO_W-1:0]      rsp_out_priority,
   output logic [WORD_W-1:0]      rsp_out_order,
   output logic [PRIO_W-1:0]      rsp_top_priority,
   output logic                   rsp_found,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CNT_W-1:0]  csr_ring_slots
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   pmss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pmss_dpath u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_we                 (csr_valid && csr_ready),
      .csr_data               (csr_ring_slots),
      .req_func               (req_func),
      .req_slot               (req_slot),
      .req_payload_first      (req_payload_first),
      .req_payload_second     (req_payload_second),
      .req_msg_priority       (req_msg_priority),
      .req_arrival_order      (req_arrival_order),
      .req_head_slot          (req_head_slot),
      .req_entry_count        (req_entry_count),
      .rsp_out_payload_first  (rsp_out_payload_first),
      .rsp_out_payload_second (rsp_out_payload_second),
      .rsp_out_priority       (rsp_out_priority),
      .rsp_out_order          (rsp_out_order),
      .rsp_top_priority       (rsp_top_priority),
      .rsp_found              (rsp_found)
   );

endmodule

`default_nettype wire

/* hdl/pmss_ctrl.sv */
`default_nettype none

module pmss_ctrl
   import pmss_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WRITE,
      S_READ,
      S_SCAN,
      S_DRAIN,
      S_SWAP_HEAD,
      S_SWAP_BEST,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      load_out;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign load_out  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cmd            = '0;
      cmd.capture    = req_valid && !req_stall;
      cmd.wr_input   = (state_ff == S_WRITE);
      cmd.rd_issue   = (state_ff == S_READ);
      cmd.scan_issue = (state_ff == S_SCAN);
      cmd.wr_head    = (state_ff == S_SWAP_HEAD);
      cmd.wr_best    = (state_ff == S_SWAP_BEST);
      cmd.load_out   = load_out;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (status.func)
               FUNC_WRITE:   state_in = S_WRITE;
               FUNC_READ:    state_in = S_READ;
               FUNC_ARRANGE: state_in = status.cnt_zero ? S_DONE : S_SCAN;
               default:      state_in = S_DONE;
            endcase
         end
         S_WRITE:     state_in = S_DONE;
         S_READ:      state_in = S_DONE;
         S_SCAN: begin
            if (status.cnt_last) state_in = S_DRAIN;
         end
         S_DRAIN:     state_in = S_SWAP_HEAD;
         S_SWAP_HEAD: state_in = S_SWAP_BEST;
         S_SWAP_BEST: state_in = S_DONE;
         S_DONE: begin
            if (load_out) state_in = S_IDLE;
         end
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && status.cnt_last |=> (state_ff == S_DRAIN))
      else $error("scan did not stop at last entry");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside done state");

   a_swap_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWAP_HEAD) |=> (state_ff == S_SWAP_BEST))
      else $error("swap left half done");

endmodule

`default_nettype wire

/* hdl/pmss_dpath.sv */
`default_nettype none

module pmss_dpath
   import pmss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic              csr_we,
   input  wire logic [CNT_W-1:0]  csr_data,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [SLOT_W-1:0] req_slot,
   input  wire logic [WORD_W-1:0] req_payload_first,
   input  wire logic [WORD_W-1:0] req_payload_second,
   input  wire logic [PRIO_W-1:0] req_msg_priority,
   input  wire logic [WORD_W-1:0] req_arrival_order,
   input  wire logic [SLOT_W-1:0] req_head_slot,
   input  wire logic [CNT_W-1:0]  req_entry_count,
   output logic [WORD_W-1:0]      rsp_out_payload_first,
   output logic [WORD_W-1:0]      rsp_out_payload_second,
   output logic [PRIO_W-1:0]      rsp_out_priority,
   output logic [WORD_W-1:0]      rsp_out_order,
   output logic [PRIO_W-1:0]      rsp_top_priority,
   output logic                   rsp_found
);

   slot_word_type mem [MAX_SLOTS];

   logic [CNT_W-1:0]  ring_ff;
   logic [CNT_W-1:0]  ring_eff;
   logic [FUNC_W-1:0] func_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] head_ff;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic              found_ff;
   logic              first_ff;
   slot_word_type     wr_word_ff;
   slot_word_type     rd_data_ff;
   logic              cmp_valid_ff, cmp_first_ff;
   logic [SLOT_W-1:0] cmp_idx_ff;
   slot_word_type     best_word_ff;
   slot_word_type     head_word_ff;
   logic [SLOT_W-1:0] best_idx_ff;
   logic              better;
   logic [CNT_W-1:0]  idx_inc;

   logic              mem_we, mem_re;
   logic [SLOT_W-1:0] wr_addr, rd_addr;
   slot_word_type     wr_data;

   logic [WORD_W-1:0] out_first_ff, out_second_ff, out_order_ff;
   logic [PRIO_W-1:0] out_prio_ff, top_prio_ff;
   logic              out_found_ff;

   // clamp ring size into 1..MAX_SLOTS
   always_comb begin
      ring_eff = ring_ff;
      if (ring_ff == '0) ring_eff = CNT_W'(1);
      if (ring_ff > CNT_MAX) ring_eff = CNT_MAX;
   end

   assign idx_inc = {1'b0, idx_ff} + CNT_W'(1);
   assign idx_in  = (idx_inc >= ring_eff) ? '0 : idx_inc[SLOT_W-1:0];

   assign status.func     = func_type'(func_ff);
   assign status.cnt_zero = !found_ff;
   assign status.cnt_last = (cnt_ff == CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff <= RING_RESET;
      end else if (csr_we) begin
         ring_ff <= csr_data;
      end
   end

   // capture the transaction, then advance the scan pointer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff           <= req_func;
         slot_ff           <= req_slot;
         head_ff           <= req_head_slot;
         idx_ff            <= req_head_slot;
         cnt_ff            <= (req_entry_count > CNT_MAX) ? CNT_MAX : req_entry_count;
         found_ff          <= (req_entry_count != '0);
         first_ff          <= 1'b1;
         wr_word_ff.first  <= req_payload_first;
         wr_word_ff.second <= req_payload_second;
         wr_word_ff.prio   <= req_msg_priority;
         wr_word_ff.order  <= req_arrival_order;
      end else if (cmd.scan_issue) begin
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_ff - CNT_W'(1);
         first_ff <= 1'b0;
      end
   end

   always_comb begin
      mem_we  = cmd.wr_input || cmd.wr_head || cmd.wr_best;
      wr_addr = slot_ff;
      wr_data = wr_word_ff;
      if (cmd.wr_head) begin
         wr_addr = head_ff;
         wr_data = best_word_ff;
      end else if (cmd.wr_best) begin
         wr_addr = best_idx_ff;
         wr_data = head_word_ff;
      end
      mem_re  = cmd.rd_issue || cmd.scan_issue;
      rd_addr = cmd.scan_issue ? idx_ff : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      if (mem_re) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
         cmp_first_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan_issue;
         cmp_first_ff <= cmd.scan_issue && first_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= idx_ff;
   end

   assign better = (rd_data_ff.prio > best_word_ff.prio) ||
                   ((rd_data_ff.prio == best_word_ff.prio) &&
                    (rd_data_ff.order < best_word_ff.order));

   // head entry seeds the candidate; later entries replace it only if better
   always_ff @(posedge clock) begin
      if (cmp_valid_ff) begin
         if (cmp_first_ff) begin
            best_word_ff <= rd_data_ff;
            head_word_ff <= rd_data_ff;
            best_idx_ff  <= cmp_idx_ff;
         end else if (better) begin
            best_word_ff <= rd_data_ff;
            best_idx_ff  <= cmp_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_first_ff  <= '0;
         out_second_ff <= '0;
         out_prio_ff   <= '0;
         out_order_ff  <= '0;
         top_prio_ff   <= '0;
         out_found_ff  <= 1'b0;
         case (func_type'(func_ff))
            FUNC_READ: begin
               out_first_ff  <= rd_data_ff.first;
               out_second_ff <= rd_data_ff.second;
               out_prio_ff   <= rd_data_ff.prio;
               out_order_ff  <= rd_data_ff.order;
            end
            FUNC_ARRANGE: begin
               if (found_ff) begin
                  top_prio_ff  <= best_word_ff.prio;
                  out_found_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_out_payload_first  = out_first_ff;
   assign rsp_out_payload_second = out_second_ff;
   assign rsp_out_priority       = out_prio_ff;
   assign rsp_out_order          = out_order_ff;
   assign rsp_top_priority       = top_prio_ff;
   assign rsp_found              = out_found_ff;

   a_best_rises: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff && !cmp_first_ff |=> best_word_ff.prio >= $past(best_word_ff.prio))
      else $error("best priority dropped during scan");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && cmd.scan_issue))
      else $error("store written during scan");

   a_found_only_arrange: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out && (func_ff != FUNC_ARRANGE) |=> !out_found_ff)
      else $error("found set for a non-arrange transaction");

endmodule

`default_nettype wire

/* tb/tb_priority_message_select_swap_unit.sv */
module tb_priority_message_select_swap_unit
   import pmss_pkg::*;
();

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES       = 7;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] first;
      logic [WORD_W-1:0] second;
      logic [PRIO_W-1:0] prio;
      logic [WORD_W-1:0] order;
      logic [SLOT_W-1:0] head;
      logic [CNT_W-1:0]  count;
   } msg_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] first;
      logic [WORD_W-1:0] second;
      logic [PRIO_W-1:0] prio;
      logic [WORD_W-1:0] order;
      logic [PRIO_W-1:0] top;
      logic              found;
   } msg_reply_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [FUNC_W-1:0] req_func = '0;
   logic [SLOT_W-1:0] req_slot = '0;
   logic [WORD_W-1:0] req_payload_first = '0;
   logic [WORD_W-1:0] req_payload_second = '0;
   logic [PRIO_W-1:0] req_msg_priority = '0;
   logic [WORD_W-1:0] req_arrival_order = '0;
   logic [SLOT_W-1:0] req_head_slot = '0;
   logic [CNT_W-1:0]  req_entry_count = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [WORD_W-1:0] rsp_out_payload_first;
   logic [WORD_W-1:0] rsp_out_payload_second;
   logic [PRIO_W-1:0] rsp_out_priority;
   logic [WORD_W-1:0] rsp_out_order;
   logic [PRIO_W-1:0] rsp_top_priority;
   logic              rsp_found;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CNT_W-1:0]  csr_ring_slots = '0;

   // predictor state
   slot_word_type     msg_store [MAX_SLOTS];
   logic [CNT_W-1:0]  ring_setting = RING_RESET;

   // stimulus side: slots that some queued write already fills
   bit                slot_filled [MAX_SLOTS];

   msg_req_type       queued_requests [$];
   msg_reply_type     predicted_replies [$];
   msg_req_type       on_bus;
   bit                req_taken = 1'b0;
   int                issued_count = 0;
   int                accepted_count = 0;
   int                fail_count = 0;
   int                idle_pct = 12;
   int                long_hold_kicks = 0;
   int                kicks_seen = 0;
   int                hold_left = 0;
   logic [CNT_W-1:0]  ring_plan [PHASES];

   priority_message_select_swap_unit i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_func               (req_func),
      .req_slot               (req_slot),
      .req_payload_first      (req_payload_first),
      .req_payload_second     (req_payload_second),
      .req_msg_priority       (req_msg_priority),
      .req_arrival_order      (req_arrival_order),
      .req_head_slot          (req_head_slot),
      .req_entry_count        (req_entry_count),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_out_payload_first  (rsp_out_payload_first),
      .rsp_out_payload_second (rsp_out_payload_second),
      .rsp_out_priority       (rsp_out_priority),
      .rsp_out_order          (rsp_out_order),
      .rsp_top_priority       (rsp_top_priority),
      .rsp_found              (rsp_found),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_ring_slots         (csr_ring_slots)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("priority_message_select_swap_unit: mismatch");
      $finish;
   end

   // ring register as the block uses it: zero acts as one, large values clamp
   function automatic int ring_span(input logic [CNT_W-1:0] r);
      if (r == '0) return 1;
      if (int'(r) > MAX_SLOTS) return MAX_SLOTS;
      return int'(r);
   endfunction

   function automatic int scan_length(input logic [CNT_W-1:0] count);
      return (int'(count) > MAX_SLOTS) ? MAX_SLOTS : int'(count);
   endfunction

   // first slot on the scan path that no write has filled yet, -1 if none
   function automatic int first_unfilled(input logic [SLOT_W-1:0] head,
                                         input logic [CNT_W-1:0] count);
      int idx;
      int n;
      int span;
      span = ring_span(ring_setting);
      idx = int'(head);
      for (n = 0; n < scan_length(count); n++) begin
         if (!slot_filled[idx]) return idx;
         idx++;
         if (idx >= span) idx = 0;
      end
      return -1;
   endfunction

   function automatic msg_reply_type apply_message_op(input msg_req_type rq);
      msg_reply_type rp;
      slot_word_type cand;
      slot_word_type held;
      int            idx;
      int            best;
      int            n;
      int            span;
      rp = '0;
      case (rq.func)
         FUNC_WRITE: begin
            msg_store[rq.slot] = '{first: rq.first, second: rq.second,
                                   prio: rq.prio, order: rq.order};
         end
         FUNC_READ: begin
            held = msg_store[rq.slot];
            rp.first = held.first;
            rp.second = held.second;
            rp.prio = held.prio;
            rp.order = held.order;
         end
         FUNC_ARRANGE: begin
            if (rq.count != '0) begin
               span = ring_span(ring_setting);
               best = int'(rq.head);
               idx = best;
               for (n = 0; n < scan_length(rq.count); n++) begin
                  cand = msg_store[idx];
                  // higher priority wins, older arrival breaks a tie
                  if (cand.prio > msg_store[best].prio ||
                      (cand.prio == msg_store[best].prio &&
                       cand.order < msg_store[best].order)) begin
                     best = idx;
                  end
                  idx++;
                  if (idx >= span) idx = 0;
               end
               held = msg_store[best];
               msg_store[best] = msg_store[rq.head];
               msg_store[rq.head] = held;
               rp.top = held.prio;
               rp.found = 1'b1;
            end
         end
         default: ;
      endcase
      return rp;
   endfunction

   function automatic msg_req_type mk_request(input logic [FUNC_W-1:0] func,
                                              input logic [SLOT_W-1:0] slot,
                                              input logic [WORD_W-1:0] first,
                                              input logic [WORD_W-1:0] second,
                                              input logic [PRIO_W-1:0] prio,
                                              input logic [WORD_W-1:0] order,
                                              input logic [SLOT_W-1:0] head,
                                              input logic [CNT_W-1:0]  count);
      msg_req_type rq;
      rq = '{func: func, slot: slot, first: first, second: second, prio: prio,
             order: order, head: head, count: count};
      if (func == FUNC_WRITE) slot_filled[slot] = 1'b1;
      return rq;
   endfunction

   function automatic msg_req_type random_request();
      msg_req_type rq;
      int          pick;
      int          gap;
      pick = $urandom_range(99);
      rq.slot = SLOT_W'($urandom_range(MAX_SLOTS - 1));
      rq.first = $urandom;
      rq.second = $urandom;
      // narrow ranges half the time so priority and order ties are common
      rq.prio = ($urandom_range(1) != 0) ? PRIO_W'($urandom_range(31))
                                         : PRIO_W'($urandom_range(3));
      rq.order = ($urandom_range(1) != 0) ? WORD_W'($urandom)
                                          : WORD_W'($urandom_range(7));
      rq.head = ($urandom_range(3) != 0) ?
                SLOT_W'($urandom_range(ring_span(ring_setting) - 1)) :
                SLOT_W'($urandom_range(MAX_SLOTS - 1));
      case ($urandom_range(9))
         0:       rq.count = '0;
         1:       rq.count = CNT_W'($urandom_range(127, MAX_SLOTS + 1));
         2:       rq.count = CNT_MAX;
         default: rq.count = CNT_W'($urandom_range(12, 1));
      endcase
      if (pick < 35) rq.func = FUNC_WRITE;
      else if (pick < 65) rq.func = FUNC_READ;
      else if (pick < 95) rq.func = FUNC_ARRANGE;
      else rq.func = FUNC_UNUSED;
      // never touch a slot that was never written: fill it instead
      if (rq.func == FUNC_READ && !slot_filled[rq.slot]) rq.func = FUNC_WRITE;
      if (rq.func == FUNC_ARRANGE) begin
         gap = first_unfilled(rq.head, rq.count);
         if (gap >= 0) begin
            rq.func = FUNC_WRITE;
            rq.slot = SLOT_W'(gap);
         end
      end
      if (rq.func == FUNC_WRITE) slot_filled[rq.slot] = 1'b1;
      return rq;
   endfunction

   task automatic offer(input msg_req_type rq);
      queued_requests.push_back(rq);
      issued_count++;
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // driver: advance to the next transaction once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (queued_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
            on_bus = queued_requests.pop_front();
            req_valid <= 1'b1;
            req_func <= on_bus.func;
            req_slot <= on_bus.slot;
            req_payload_first <= on_bus.first;
            req_payload_second <= on_bus.second;
            req_msg_priority <= on_bus.prio;
            req_arrival_order <= on_bus.order;
            req_head_slot <= on_bus.head;
            req_entry_count <= on_bus.count;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off when kicked
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_kicks != kicks_seen) begin
         kicks_seen = long_hold_kicks;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // monitor: predict on accept, compare each delivered result in order
   always @(posedge clock) begin
      msg_reply_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            predicted_replies.push_back(apply_message_op(on_bus));
            accepted_count++;
         end
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (predicted_replies.size() == 0) begin
               $display("%0t: result with none expected, payload %h %h", $time,
                        rsp_out_payload_first, rsp_out_payload_second);
               fail_count++;
            end else begin
               want = predicted_replies.pop_front();
               check_field("out_payload_first", want.first, rsp_out_payload_first);
               check_field("out_payload_second", want.second, rsp_out_payload_second);
               check_field("out_priority", WORD_W'(want.prio), WORD_W'(rsp_out_priority));
               check_field("out_order", want.order, rsp_out_order);
               check_field("top_priority", WORD_W'(want.top), WORD_W'(rsp_top_priority));
               check_field("found", WORD_W'(want.found), WORD_W'(rsp_found));
            end
         end
      end
   end

   initial begin
      int p;
      int b;
      int k;
      int batch;
      ring_plan[0] = CNT_W'(64);
      ring_plan[1] = CNT_W'(1);
      ring_plan[2] = CNT_W'(0);
      ring_plan[3] = CNT_W'(127);
      ring_plan[4] = CNT_W'(17);
      ring_plan[5] = CNT_W'(64);
      ring_plan[6] = CNT_W'($urandom_range(63, 2));
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (p = 0; p < PHASES; p++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_ring_slots <= ring_plan[p];
         do @(posedge clock); while (csr_ready !== 1'b1);
         ring_setting = ring_plan[p];
         @(negedge clock);
         csr_valid <= 1'b0;
         // one phase runs with no idling on either side
         idle_pct = (p == 3) ? 0 : 12;
         if (p == 0) begin
            offer(mk_request(FUNC_WRITE, 6'd0, '1, '1, 5'd31, '1, 6'd0, 7'd0));
            offer(mk_request(FUNC_WRITE, 6'd63, '0, '0, 5'd0, '0, 6'd63, 7'd127));
            offer(mk_request(FUNC_WRITE, 6'd1, 32'ha5a5a5a5, 32'h5a5a5a5a, 5'd31,
                             32'd5, 6'd0, 7'd1));
            offer(mk_request(FUNC_WRITE, 6'd2, 32'h12345678, 32'h9abcdef0, 5'd0,
                             32'd0, 6'd0, 7'd0));
            offer(mk_request(FUNC_READ, 6'd0, '0, '0, '0, '0, 6'd0, 7'd0));
            offer(mk_request(FUNC_READ, 6'd63, '1, '1, '1, '1, 6'd63, 7'd127));
            // zero count: nothing moves
            offer(mk_request(FUNC_ARRANGE, 6'd0, '0, '0, '0, '0, 6'd0, 7'd0));
            offer(mk_request(FUNC_UNUSED, 6'd63, '1, '1, '1, '1, 6'd63, 7'd127));
            // equal top priority: the older arrival moves to the head
            offer(mk_request(FUNC_ARRANGE, 6'd0, '0, '0, '0, '0, 6'd0, 7'd3));
            offer(mk_request(FUNC_READ, 6'd0, '0, '0, '0, '0, 6'd0, 7'd0));
            offer(mk_request(FUNC_READ, 6'd1, '0, '0, '0, '0, 6'd0, 7'd0));
            // scan wraps from the last slot to slot zero
            offer(mk_request(FUNC_ARRANGE, 6'd0, '0, '0, '0, '0, 6'd63, 7'd2));
            offer(mk_request(FUNC_READ, 6'd63, '0, '0, '0, '0, 6'd0, 7'd0));
            // all priorities zero: the head stays the winner
            offer(mk_request(FUNC_ARRANGE, 6'd0, '0, '0, '0, '0, 6'd2, 7'd1));
            offer(mk_request(FUNC_WRITE, 6'd3, 32'hffff0000, 32'h0000ffff, 5'd0,
                             32'd0, 6'd0, 7'd0));
            offer(mk_request(FUNC_ARRANGE, 6'd0, '0, '0, '0, '0, 6'd2, 7'd2));
            offer(mk_request(FUNC_READ, 6'd2, '0, '0, '0, '0, 6'd0, 7'd0));
            offer(mk_request(FUNC_READ, 6'd3, '0, '0, '0, '0, 6'd0, 7'd0));
         end
         batch = (p == 0) ? 50 : 38;
         for (b = 0; b < 2; b++) begin
            for (k = 0; k < batch; k++) offer(random_request());
            // hold the result side off while requests keep coming
            if (p == 1 && b == 0) long_hold_kicks++;
            // pause the sender until every result is back
            while (accepted_count != issued_count || predicted_replies.size() != 0)
               @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
      end
      if (fail_count == 0) begin
         $display("priority_message_select_swap_unit: match");
      end else begin
         $display("priority_message_select_swap_unit: mismatch");
      end
      $finish;
   end

endmodule
